// ===== rtl/sp2p_pkg.sv =====
// Shared types, widths and constants of the scan point filter.
package sp2p_pkg;

  // Datapath widths: CORDIC x/y, residual angle, point before saturation
  localparam int XW = 35;
  localparam int ZW = 34;
  localparam int PW = 20;

  // 0.607253 in Q16, CORDIC gain compensation
  localparam logic [15:0] GAIN_Q16 = 16'd39797;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_START_ANGLE  = 3'd0,
    REG_ANGLE_STEP   = 3'd1,
    REG_RANGE_FLOOR  = 3'd2,
    REG_RANGE_CEIL   = 3'd3,
    REG_SENSOR_X     = 3'd4,
    REG_SENSOR_Y     = 3'd5,
    REG_BOX_HALF_X   = 3'd6,
    REG_BOX_HALF_Y   = 3'd7
  } reg_idx_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [31:0]        start_angle;
    logic [31:0]        angle_step;
    logic [15:0]        range_floor_mm;
    logic [15:0]        range_ceiling_mm;
    logic signed [15:0] sensor_x_mm;
    logic signed [15:0] sensor_y_mm;
    logic [14:0]        box_half_x_mm;
    logic [14:0]        box_half_y_mm;
  } cfg_t;

  // Item state travelling through the rotation stages
  typedef struct packed {
    logic                 keep;
    logic                 done;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cstate_t;

  // Arctangent of 2^-i in binary angle units
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517C;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000517;
      5'd20:   v = 32'h0000028B;
      5'd21:   v = 32'h00000145;
      5'd22:   v = 32'h000000A2;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/sp2p_regs.sv =====
// APB register file holding the filter configuration.
module sp2p_regs
  import sp2p_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign cfg    = cfg_r;

  // Register writes, reset loads the defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_angle      <= 32'd0;
      cfg_r.angle_step       <= 32'd0;
      cfg_r.range_floor_mm   <= 16'd0;
      cfg_r.range_ceiling_mm <= 16'd4000;
      cfg_r.sensor_x_mm      <= 16'sd90;
      cfg_r.sensor_y_mm      <= 16'sd60;
      cfg_r.box_half_x_mm    <= 15'd180;
      cfg_r.box_half_y_mm    <= 15'd180;
    end else if (wr_en) begin
      unique case (idx)
        REG_START_ANGLE: cfg_r.start_angle      <= pwdata;
        REG_ANGLE_STEP:  cfg_r.angle_step       <= pwdata;
        REG_RANGE_FLOOR: cfg_r.range_floor_mm   <= pwdata[15:0];
        REG_RANGE_CEIL:  cfg_r.range_ceiling_mm <= pwdata[15:0];
        REG_SENSOR_X:    cfg_r.sensor_x_mm      <= signed'(pwdata[15:0]);
        REG_SENSOR_Y:    cfg_r.sensor_y_mm      <= signed'(pwdata[15:0]);
        REG_BOX_HALF_X:  cfg_r.box_half_x_mm    <= pwdata[14:0];
        REG_BOX_HALF_Y:  cfg_r.box_half_y_mm    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_START_ANGLE: prdata = cfg_r.start_angle;
      REG_ANGLE_STEP:  prdata = cfg_r.angle_step;
      REG_RANGE_FLOOR: prdata = {16'd0, cfg_r.range_floor_mm};
      REG_RANGE_CEIL:  prdata = {16'd0, cfg_r.range_ceiling_mm};
      REG_SENSOR_X:    prdata = {{16{cfg_r.sensor_x_mm[15]}}, cfg_r.sensor_x_mm};
      REG_SENSOR_Y:    prdata = {{16{cfg_r.sensor_y_mm[15]}}, cfg_r.sensor_y_mm};
      REG_BOX_HALF_X:  prdata = {17'd0, cfg_r.box_half_x_mm};
      REG_BOX_HALF_Y:  prdata = {17'd0, cfg_r.box_half_y_mm};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/sp2p_front.sv =====
// Front stages: sample gating, angle computation and quadrant fold.
module sp2p_front
  import sp2p_pkg::*;
#(
  parameter int SAMPLE_STRIDE = 2,
  parameter int MAX_SAMPLES   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_idx,
  input  logic [15:0] in_range,
  input  logic        in_rvalid,
  input  logic        in_end,
  output logic        out_v,
  input  logic        out_rdy,
  output cstate_t     out_d
);

  // Stride test by reciprocal: q = floor(idx / stride) exact for 12-bit idx
  localparam int          RCP_SH = 24;
  localparam logic [24:0] RCP    = 25'(((1 << RCP_SH) + SAMPLE_STRIDE - 1) / SAMPLE_STRIDE);
  localparam logic [4:0]  STRIDE_C = 5'(SAMPLE_STRIDE);
  localparam logic [16:0] MAX_C    = 17'(MAX_SAMPLES);

  // Stage 1 registers
  logic        v1_r;
  logic [11:0] idx1_r;
  logic [15:0] rng1_r;
  logic        ok1_r, end1_r;
  logic [31:0] prod1_r;
  logic [11:0] quo1_r;
  // Stage 2 registers
  logic        v2_r;
  logic        ok2_r, end2_r;
  logic [31:0] ang2_r;
  logic [31:0] x2_r;
  // Stage 3 registers
  logic        v3_r;
  cstate_t     d3_r;

  logic        rdy1, rdy2, rdy3;
  logic [43:0] step_prod;
  logic [36:0] rcp_prod;
  logic [16:0] back_prod;
  logic        ok1_nxt, ok2_nxt, flip;
  logic [31:0] ang2_nxt, ang_fold;
  cstate_t     d3_nxt;

  assign rdy3     = !v3_r || out_rdy;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign out_v    = v3_r;
  assign out_d    = d3_r;

  // Stage 1: range window, index limit, angle and stride products
  assign step_prod = cfg.angle_step * in_idx;
  assign rcp_prod  = RCP * in_idx;
  assign ok1_nxt   = in_rvalid && (in_range > cfg.range_floor_mm)
                     && (in_range <= cfg.range_ceiling_mm)
                     && ({5'd0, in_idx} < MAX_C);

  // Stage 2: angle sum, stride match, gain-compensated range
  assign back_prod = quo1_r * STRIDE_C;
  assign ok2_nxt   = ok1_r && (back_prod == {5'd0, idx1_r});
  assign ang2_nxt  = cfg.start_angle + prod1_r;

  // Stage 3: fold quadrants two and three by a half turn
  assign flip     = ang2_r[31] ^ ang2_r[30];
  assign ang_fold = {ang2_r[31] ^ flip, ang2_r[30:0]};
  always_comb begin
    d3_nxt.keep = ok2_r;
    d3_nxt.done = end2_r;
    d3_nxt.x    = flip ? -signed'({3'd0, x2_r}) : signed'({3'd0, x2_r});
    d3_nxt.y    = '0;
    d3_nxt.z    = signed'({{(ZW-32){ang_fold[31]}}, ang_fold});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      idx1_r  <= in_idx;
      rng1_r  <= in_range;
      ok1_r   <= ok1_nxt;
      end1_r  <= in_end;
      prod1_r <= step_prod[31:0];
      quo1_r  <= rcp_prod[RCP_SH+11:RCP_SH];
    end
    if (rdy2 && v1_r) begin
      ok2_r  <= ok2_nxt;
      end2_r <= end1_r;
      ang2_r <= ang2_nxt;
      x2_r   <= rng1_r * GAIN_Q16;
    end
    if (rdy3 && v2_r) begin
      d3_r <= d3_nxt;
    end
  end

  // An invalid sample never comes out of stage 1 marked as kept
  a_invalid_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_rvalid |=> !ok1_r)
    else $error("invalid sample kept in stage 1");

  // A stalled stage 3 holds its item
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out_rdy |=> v3_r && $stable(d3_r))
    else $error("stage 3 item changed under stall");

  // Residual angle after the fold lies within a quarter turn
  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (d3_r.z[ZW-1:30] == '0) || (d3_r.z[ZW-1:30] == '1))
    else $error("folded angle out of range");

endmodule

// ===== rtl/sp2p_cordic_stage.sv =====
// One pipelined CORDIC rotation step.
module sp2p_cordic_stage
  import sp2p_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_v,
  output logic    in_rdy,
  input  cstate_t in_d,
  output logic    out_v,
  input  logic    out_rdy,
  output cstate_t out_d
);

  localparam logic signed [ZW-1:0] ATAN = signed'({{(ZW-32){1'b0}}, atan_lut(5'(IDX))});

  logic    v_r;
  cstate_t d_r;
  cstate_t d_nxt;
  logic signed [XW-1:0] dx, dy;

  assign in_rdy = !v_r || out_rdy;
  assign out_v  = v_r;
  assign out_d  = d_r;

  // Rotate toward zero residual angle
  assign dx = in_d.y >>> IDX;
  assign dy = in_d.x >>> IDX;
  always_comb begin
    d_nxt = in_d;
    if (!in_d.z[ZW-1]) begin
      d_nxt.x = in_d.x - dx;
      d_nxt.y = in_d.y + dy;
      d_nxt.z = in_d.z - ATAN;
    end else begin
      d_nxt.x = in_d.x + dx;
      d_nxt.y = in_d.y - dy;
      d_nxt.z = in_d.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_rdy) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_v) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ===== rtl/sp2p_back.sv =====
// Back stages: rounding, sensor offset, robot box test and saturation.
module sp2p_back
  import sp2p_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_v,
  output logic               in_rdy,
  input  cstate_t            in_d,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_keep,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic               out_done
);

  localparam logic signed [XW-1:0] HALF = XW'(32768);

  // Stage 1 registers
  logic                 v1_r;
  logic                 keep1_r, done1_r;
  logic signed [PW-1:0] px1_r, py1_r;
  // Output registers
  logic                 v2_r;
  logic                 keep2_r, done2_r;
  logic signed [15:0]   x2_r, y2_r;

  logic                 rdy1, rdy2;
  logic signed [XW-1:0] xr, yr;
  logic signed [PW-1:0] px_nxt, py_nxt;
  logic [PW-1:0]        ax, ay;
  logic                 inbox, keep2_nxt;
  logic signed [15:0]   sx, sy;

  assign rdy2      = !v2_r || out_ready;
  assign rdy1      = !v1_r || rdy2;
  assign in_rdy    = rdy1;
  assign out_valid = v2_r;
  assign out_keep  = keep2_r;
  assign out_x     = x2_r;
  assign out_y     = y2_r;
  assign out_done  = done2_r;

  // Stage 1: round to mm and add sensor offset
  assign xr     = in_d.x + HALF;
  assign yr     = in_d.y + HALF;
  assign px_nxt = signed'({xr[XW-1], xr[XW-1:16]})
                  + signed'({{(PW-16){cfg.sensor_x_mm[15]}}, cfg.sensor_x_mm});
  assign py_nxt = signed'({yr[XW-1], yr[XW-1:16]})
                  + signed'({{(PW-16){cfg.sensor_y_mm[15]}}, cfg.sensor_y_mm});

  // Stage 2: inclusive box test, then saturate
  assign ax        = px1_r[PW-1] ? PW'(-px1_r) : PW'(px1_r);
  assign ay        = py1_r[PW-1] ? PW'(-py1_r) : PW'(py1_r);
  assign inbox     = (ax <= {{(PW-15){1'b0}}, cfg.box_half_x_mm})
                     && (ay <= {{(PW-15){1'b0}}, cfg.box_half_y_mm});
  assign keep2_nxt = keep1_r && !inbox;

  always_comb begin
    if (px1_r[PW-1:15] == '0 || px1_r[PW-1:15] == '1) sx = px1_r[15:0];
    else if (px1_r[PW-1])                             sx = 16'sh8000;
    else                                              sx = 16'sh7FFF;
    if (py1_r[PW-1:15] == '0 || py1_r[PW-1:15] == '1) sy = py1_r[15:0];
    else if (py1_r[PW-1])                             sy = 16'sh8000;
    else                                              sy = 16'sh7FFF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_v;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_v) begin
      keep1_r <= in_d.keep;
      done1_r <= in_d.done;
      px1_r   <= px_nxt;
      py1_r   <= py_nxt;
    end
    if (rdy2 && v1_r) begin
      keep2_r <= keep2_nxt;
      done2_r <= done1_r;
      x2_r    <= keep2_nxt ? sx : 16'sd0;
      y2_r    <= keep2_nxt ? sy : 16'sd0;
    end
  end

  // A dropped sample carries a zero point
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_keep |-> out_x == 16'sd0 && out_y == 16'sd0)
    else $error("dropped sample with nonzero point");

  // Stage 1 holds its item while the output waits
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !rdy2 |=> v1_r && $stable(px1_r) && $stable(keep1_r))
    else $error("stage 1 item changed under stall");

  // Nothing kept comes from a dropped upstream item
  a_keep_chain: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && rdy2 && !keep1_r |=> !out_keep)
    else $error("dropped item became kept");

endmodule

// ===== rtl/scan_polar_to_point_filter.sv =====
// Top level of the lidar scan filter: registers, front, CORDIC chain, back.
// Each item passes the front stages, the CORDIC_STAGES rotation stages and the back stages before out_valid.
// Throughput: one item per cycle while out_ready is high; every stage has its own valid bit and the
// ready chain lets bubbles close up while a result waits at the output.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
module scan_polar_to_point_filter
  import sp2p_pkg::*;
#(
  parameter int SAMPLE_STRIDE = 2,
  parameter int MAX_SAMPLES   = 4096,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // sample input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        in_sample_index,
  input  logic [15:0]        in_range_mm,
  input  logic               in_range_valid,
  input  logic               in_scan_end,
  // point output
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_keep,
  output logic signed [15:0] out_point_x_mm,
  output logic signed [15:0] out_point_y_mm,
  output logic               out_scan_done
);

  cfg_t                   cfg;
  cstate_t                cd [0:CORDIC_STAGES];
  logic [CORDIC_STAGES:0] cv;
  logic [CORDIC_STAGES:0] cr;

  // Configuration registers
  sp2p_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Gating, angle and fold
  sp2p_front #(
    .SAMPLE_STRIDE (SAMPLE_STRIDE),
    .MAX_SAMPLES   (MAX_SAMPLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_idx    (in_sample_index),
    .in_range  (in_range_mm),
    .in_rvalid (in_range_valid),
    .in_end    (in_scan_end),
    .out_v     (cv[0]),
    .out_rdy   (cr[0]),
    .out_d     (cd[0])
  );

  // CORDIC rotation chain, one stage per iteration
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    sp2p_cordic_stage #(.IDX(k)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_v    (cv[k]),
      .in_rdy  (cr[k]),
      .in_d    (cd[k]),
      .out_v   (cv[k+1]),
      .out_rdy (cr[k+1]),
      .out_d   (cd[k+1])
    );
  end

  // Offset, box test, saturation and output register
  sp2p_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_v      (cv[CORDIC_STAGES]),
    .in_rdy    (cr[CORDIC_STAGES]),
    .in_d      (cd[CORDIC_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_keep  (out_keep),
    .out_x     (out_point_x_mm),
    .out_y     (out_point_y_mm),
    .out_done  (out_scan_done)
  );

  // A ready sink propagates all the way to the input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("pipeline stalled with a ready sink");

  // The pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // A rotation stage never stalls while the back end accepts
  a_chain_flow: assert property (@(posedge clk) disable iff (!rst_n)
    cr[CORDIC_STAGES] |-> cr[0])
    else $error("CORDIC chain stalled with a ready back end");

endmodule

// ===== bench/sp2p_point_checker.sv =====
// Scoreboard for the scan point filter: tracks register writes, predicts each point, compares.
`timescale 1ns / 100ps

module sp2p_point_checker
  import sp2p_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [11:0]        in_sample_index,
  input  logic [15:0]        in_range_mm,
  input  logic               in_range_valid,
  input  logic               in_scan_end,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_keep,
  input  logic signed [15:0] out_point_x_mm,
  input  logic signed [15:0] out_point_y_mm,
  input  logic               out_scan_done,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int STRIDE  = 2;
  localparam int STAGES  = 16;
  localparam longint GAIN = 39797;

  // atan(2^-i) as a fraction of a full turn scaled by 2^32
  localparam logic [31:0] ATAN_TURNS [STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
  };

  typedef struct {
    logic               keep;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic               done;
  } point_t;

  // Local copy of the register file
  logic [31:0]        start_angle;
  logic [31:0]        angle_step;
  logic [15:0]        range_floor;
  logic [15:0]        range_ceiling;
  logic signed [15:0] sensor_x;
  logic signed [15:0] sensor_y;
  logic [14:0]        box_half_x;
  logic [14:0]        box_half_y;

  point_t expected_points [$];

  initial fail_count = 0;
  initial pending_count = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic logic signed [15:0] clamp_mm(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Polar sample to robot-frame point, keep decision included
  function automatic point_t filter_sample(input logic [11:0] idx, input logic [15:0] rng,
                                           input logic vld, input logic last);
    point_t p;
    logic [31:0] ang;
    longint cx, cy, cz, dx, dy, px, py, ax, ay;
    p.keep = 1'b0;
    p.x_mm = '0;
    p.y_mm = '0;
    p.done = last;
    if ((idx % STRIDE) == 0 && vld && rng > range_floor && rng <= range_ceiling) begin
      ang = start_angle + angle_step * {20'b0, idx};
      cx = longint'(rng) * GAIN;
      cy = 0;
      // fold quadrants two and three onto the right half plane
      if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
        cx = -cx;
        ang = ang + 32'h8000_0000;
      end
      cz = longint'(signed'(ang));
      for (int i = 0; i < STAGES; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cz >= 0) begin
          cx = cx - dx;
          cy = cy + dy;
          cz = cz - longint'(ATAN_TURNS[i]);
        end else begin
          cx = cx + dx;
          cy = cy - dy;
          cz = cz + longint'(ATAN_TURNS[i]);
        end
      end
      px = ((cx + 32768) >>> 16) + longint'(sensor_x);
      py = ((cy + 32768) >>> 16) + longint'(sensor_y);
      ax = (px < 0) ? -px : px;
      ay = (py < 0) ? -py : py;
      // inside the padded footprint (bounds inclusive) is self-return
      if (!(ax <= longint'(box_half_x) && ay <= longint'(box_half_y))) begin
        p.keep = 1'b1;
        p.x_mm = clamp_mm(px);
        p.y_mm = clamp_mm(py);
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      start_angle   = '0;
      angle_step    = '0;
      range_floor   = 16'd0;
      range_ceiling = 16'd4000;
      sensor_x      = 16'sd90;
      sensor_y      = 16'sd60;
      box_half_x    = 15'd180;
      box_half_y    = 15'd180;
      expected_points.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_START_ANGLE: start_angle   = pwdata;
          REG_ANGLE_STEP:  angle_step    = pwdata;
          REG_RANGE_FLOOR: range_floor   = pwdata[15:0];
          REG_RANGE_CEIL:  range_ceiling = pwdata[15:0];
          REG_SENSOR_X:    sensor_x      = pwdata[15:0];
          REG_SENSOR_Y:    sensor_y      = pwdata[15:0];
          REG_BOX_HALF_X:  box_half_x    = pwdata[14:0];
          REG_BOX_HALF_Y:  box_half_y    = pwdata[14:0];
          default: ;
        endcase
      end
      // sample accepted
      if (in_valid && in_ready)
        expected_points.insert(expected_points.size(),
                               filter_sample(in_sample_index, in_range_mm,
                                             in_range_valid, in_scan_end));
      // point delivered
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("point with none expected, keep", out_keep, 0);
        end else begin
          want = expected_points.pop_front();
          if (out_keep !== want.keep)
            report_mismatch("keep", out_keep, want.keep);
          if (out_point_x_mm !== want.x_mm)
            report_mismatch("point_x_mm", out_point_x_mm, want.x_mm);
          if (out_point_y_mm !== want.y_mm)
            report_mismatch("point_y_mm", out_point_y_mm, want.y_mm);
          if (out_scan_done !== want.done)
            report_mismatch("scan_done", out_scan_done, want.done);
        end
      end
    end
    pending_count <= expected_points.size();
  end

endmodule

// ===== bench/tb.sv =====
// Top of the scan point filter bench: clock, reset, register setup and sample traffic.
`timescale 1ns / 100ps

module tb
  import sp2p_pkg::*;
();

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [11:0]        in_sample_index = '0;
  logic [15:0]        in_range_mm = '0;
  logic               in_range_valid = 1'b0;
  logic               in_scan_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_keep;
  logic signed [15:0] out_point_x_mm;
  logic signed [15:0] out_point_y_mm;
  logic               out_scan_done;

  int fail_count;
  int pending_count;
  bit idle_on = 1'b1;
  int stall_left = 0;

  // Current register values, used to aim random ranges at the pass band
  logic [15:0] floor_now = 16'd0;
  logic [15:0] ceil_now  = 16'd4000;

  scan_polar_to_point_filter DUT (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .in_sample_index, .in_range_mm, .in_range_valid, .in_scan_end,
    .out_valid, .out_ready, .out_keep, .out_point_x_mm, .out_point_y_mm, .out_scan_done
  );

  sp2p_point_checker u_check (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_ready, .in_sample_index, .in_range_mm, .in_range_valid, .in_scan_end,
    .out_valid, .out_ready, .out_keep, .out_point_x_mm, .out_point_y_mm, .out_scan_done,
    .fail_count, .pending_count
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(7, 0) == 0) begin
      stall_left <= $urandom_range(18, 0);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hand one sample to the block, with an occasional idle burst first
  task automatic push_sample(input logic [11:0] idx, input logic [15:0] rng,
                             input logic vld, input logic last);
    if (idle_on && $urandom_range(5, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_index <= idx;
    in_range_mm     <= rng;
    in_range_valid  <= vld;
    in_scan_end     <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Setup then access phase; the register takes the value on the access edge,
  // then the bus returns to idle
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    in_valid <= 1'b0;
    psel     <= 1'b1;
    penable  <= 1'b0;
    pwrite   <= 1'b1;
    paddr    <= {idx, 2'b00};
    pwdata   <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [31:0] start, input logic [31:0] step,
                           input logic [15:0] lo, input logic [15:0] hi,
                           input logic [15:0] sx, input logic [15:0] sy,
                           input logic [14:0] bx, input logic [14:0] by);
    cfg_write(REG_START_ANGLE, start);
    cfg_write(REG_ANGLE_STEP, step);
    cfg_write(REG_RANGE_FLOOR, {16'b0, lo});
    cfg_write(REG_RANGE_CEIL, {16'b0, hi});
    cfg_write(REG_SENSOR_X, {16'b0, sx});
    cfg_write(REG_SENSOR_Y, {16'b0, sy});
    cfg_write(REG_BOX_HALF_X, {17'b0, bx});
    cfg_write(REG_BOX_HALF_Y, {17'b0, by});
    floor_now = lo;
    ceil_now  = hi;
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    logic [11:0] idx;
    logic [15:0] rng;
    logic [31:0] start, step;
    logic [15:0] lo, hi, sx, sy;
    logic [14:0] bx, by;
    int sel;
    int n_items;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: angle zero, ceiling 4000, box 180 around the origin, sensor at (90, 60)
    push_sample(12'd0,    16'd1000,  1'b1, 1'b0);
    push_sample(12'd4095, 16'd1000,  1'b1, 1'b0);  // off-stride index
    push_sample(12'd4094, 16'd0,     1'b1, 1'b0);  // range at the floor
    push_sample(12'd2,    16'd4000,  1'b1, 1'b0);  // range at the ceiling
    push_sample(12'd4,    16'd4001,  1'b1, 1'b0);  // just above the ceiling
    push_sample(12'd6,    16'd65535, 1'b1, 1'b0);
    push_sample(12'd8,    16'd2000,  1'b0, 1'b0);  // invalid sample
    push_sample(12'd10,   16'd90,    1'b1, 1'b0);  // on the box edge
    push_sample(12'd12,   16'd91,    1'b1, 1'b0);  // just past the box edge
    push_sample(12'd14,   16'd1,     1'b1, 1'b1);  // inside the box, end of scan
    wait_drained();

    // Eighth-turn sweep through all quadrants, far sensor offsets, saturation
    write_all(32'h0, 32'h1000_0000, 16'd0, 16'hFFFF, 16'h7FFF, 16'h8000, 15'd0, 15'd0);
    for (int k = 0; k < 14; k++)
      push_sample(12'(2 * k), (k % 2) ? 16'hFFFF : 16'd3000, 1'b1, k == 13);
    wait_drained();

    // Random phases, each under fresh register values
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          start = 32'h0; step = 32'hFFFF_FFFF; lo = 16'd0; hi = 16'd0;
          sx = 16'h8000; sy = 16'h7FFF; bx = 15'h7FFF; by = 15'h7FFF;
        end
        1: begin
          start = 32'hFFFF_FFFF; step = 32'd1; lo = 16'hFFFE; hi = 16'hFFFF;
          sx = 16'h0; sy = 16'h0; bx = 15'd0; by = 15'd0;
        end
        2: begin
          start = $urandom; step = $urandom; lo = 16'd0; hi = 16'hFFFF;
          sx = 16'h7FFF; sy = 16'h7FFF; bx = 15'h7FFF; by = 15'd0;
        end
        default: begin
          start = $urandom;
          step  = ($urandom_range(1, 0) == 0) ? $urandom : 32'($urandom_range(4_000_000, 0));
          lo    = 16'($urandom_range(400, 0));
          hi    = ($urandom_range(2, 0) == 0) ? 16'hFFFF : 16'($urandom_range(20000, 500));
          sx    = 16'($urandom_range(400, 0) - 200);
          sy    = 16'($urandom_range(400, 0) - 200);
          bx    = ($urandom_range(5, 0) == 0) ? 15'($urandom) : 15'($urandom_range(400, 0));
          by    = ($urandom_range(5, 0) == 0) ? 15'($urandom) : 15'($urandom_range(400, 0));
        end
      endcase
      write_all(start, step, lo, hi, sx, sy, bx, by);
      if (ph == 6) idle_on = 1'b0;
      n_items = (ph == 0) ? 40 : 145;
      for (int n = 0; n < n_items; n++) begin
        idx = 12'($urandom);
        if ($urandom_range(9, 0) < 7) idx[0] = 1'b0;
        sel = $urandom_range(15, 0);
        if (sel == 0)
          rng = floor_now;
        else if (sel == 1)
          rng = ceil_now;
        else if (sel < 12 && ceil_now > floor_now)
          rng = 16'($urandom_range(ceil_now, floor_now + 1));
        else
          rng = 16'($urandom);
        push_sample(idx, rng, $urandom_range(7, 0) != 0, $urandom_range(9, 0) == 0);
      end
      wait_drained();
    end

    // Let anything stray still in the pipeline come out
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
